// File: hw/rtl/tbw_pkg.sv
package tbw_pkg;

    localparam int COORD_W   = 32;
    localparam int VEC_W     = COORD_W + 1;
    localparam int MUL_W     = VEC_W + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int PAIR_W    = 2 * VEC_W;
    localparam int MINOR_W   = PAIR_W + 1;
    localparam int SPLIT     = VEC_W + 1;
    localparam int ACC_W     = MINOR_W + VEC_W + 4;
    localparam int FRAC_OUT  = 28;
    localparam int Q_W       = 34;
    localparam int DIV_W     = ACC_W + Q_W + 1;
    localparam int OUT_W     = 32;
    localparam int NUM_VERTS = 4;
    localparam int NUM_DETS  = 5;
    localparam int NUM_VECS  = 7;
    localparam int LAST_PH   = 5;

    localparam logic [2:0] SLOT_QUERY = 3'd4;

    // vector ids: 0..2 edges from vertex 0, 3..5 vertex minus point, 6 point minus vertex 0
    localparam logic [2:0] VID_E0 = 3'd0;
    localparam logic [2:0] VID_E1 = 3'd1;
    localparam logic [2:0] VID_E2 = 3'd2;
    localparam logic [2:0] VID_F0 = 3'd3;
    localparam logic [2:0] VID_F1 = 3'd4;
    localparam logic [2:0] VID_F2 = 3'd5;
    localparam logic [2:0] VID_G  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DSET,
        ST_DIV,
        ST_WFIN,
        ST_OUT
    } state_t;

    // column vector of determinant det (0 = denominator, 1..4 = numerators) at column pos
    function automatic logic [2:0] det_vec(input logic [2:0] det, input logic [1:0] pos);
        logic [2:0] v;
        v = VID_E0;
        case (det)
            3'd0: v = (pos == 2'd0) ? VID_E0 : (pos == 2'd1) ? VID_E1 : VID_E2;
            3'd1: v = (pos == 2'd0) ? VID_F0 : (pos == 2'd1) ? VID_F1 : VID_F2;
            3'd2: v = (pos == 2'd0) ? VID_G  : (pos == 2'd1) ? VID_E1 : VID_E2;
            3'd3: v = (pos == 2'd0) ? VID_E0 : (pos == 2'd1) ? VID_G  : VID_E2;
            3'd4: v = (pos == 2'd0) ? VID_E0 : (pos == 2'd1) ? VID_E1 : VID_G;
            default: v = VID_E0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/tetrahedron_barycentric_weights.sv
// channel | direction | beat payload                                   | handshake
// s_      | in        | slot, coord_x, coord_y, coord_z                | s_valid / s_ready
// m_      | out       | weight_a..weight_d, degenerate                 | m_valid / m_ready
//
// A vertex beat (slot 0..3) or an unused slot is taken in ST_IDLE, which it does not leave.
// A query beat runs 5 determinants x 3 terms, each term stepping ph_reg through 0..LAST_PH
// on one 35x35 multiplier, then 4 restoring divisions (ST_DSET, ST_DIV, ST_WFIN) on one
// wide subtractor; the divisions are skipped when the denominator determinant is zero.
// Reset clears the vertex store and all control state.
// The result register holds a beat while m_ready is low; vertex beats are taken meanwhile,
// and a finished query waits until the register is free.
module tetrahedron_barycentric_weights (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_slot,
    input  logic signed [tbw_pkg::COORD_W-1:0]  s_coord_x,
    input  logic signed [tbw_pkg::COORD_W-1:0]  s_coord_y,
    input  logic signed [tbw_pkg::COORD_W-1:0]  s_coord_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tbw_pkg::OUT_W-1:0]    m_weight_a,
    output logic signed [tbw_pkg::OUT_W-1:0]    m_weight_b,
    output logic signed [tbw_pkg::OUT_W-1:0]    m_weight_c,
    output logic signed [tbw_pkg::OUT_W-1:0]    m_weight_d,
    output logic                                m_degenerate
);

    localparam int COORD_W = tbw_pkg::COORD_W;
    localparam int VEC_W   = tbw_pkg::VEC_W;
    localparam int MUL_W   = tbw_pkg::MUL_W;
    localparam int PROD_W  = tbw_pkg::PROD_W;
    localparam int PAIR_W  = tbw_pkg::PAIR_W;
    localparam int MINOR_W = tbw_pkg::MINOR_W;
    localparam int SPLIT   = tbw_pkg::SPLIT;
    localparam int ACC_W   = tbw_pkg::ACC_W;
    localparam int DIV_W   = tbw_pkg::DIV_W;
    localparam int Q_W     = tbw_pkg::Q_W;
    localparam int OUT_W   = tbw_pkg::OUT_W;

    tbw_pkg::state_t state_reg, state_next;

    logic [COORD_W-1:0]        vtx_reg [tbw_pkg::NUM_VERTS][3];
    logic signed [VEC_W-1:0]   vx_reg [tbw_pkg::NUM_VECS];
    logic signed [VEC_W-1:0]   vy_reg [tbw_pkg::NUM_VECS];
    logic signed [VEC_W-1:0]   vz_reg [tbw_pkg::NUM_VECS];

    logic [2:0]                det_reg;
    logic [1:0]                term_reg;
    logic [2:0]                ph_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MINOR_W-1:0] minor_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   dets_reg [tbw_pkg::NUM_DETS];

    logic [ACC_W-1:0]          ad_reg;
    logic [1:0]                widx_reg;
    logic [5:0]                bit_reg;
    logic [DIV_W-1:0]          rem_reg;
    logic [DIV_W-1:0]          dsh_reg;
    logic [Q_W-1:0]            q_reg;
    logic                      ovf_reg;
    logic                      neg_reg;
    logic [OUT_W-1:0]          wt_reg [tbw_pkg::NUM_VERTS];
    logic                      deg_reg;
    logic                      m_valid_reg;

    logic                      in_beat;
    logic                      out_free;
    logic                      mul_last;
    logic                      div_last;
    logic [1:0]                j1, j2;
    logic [2:0]                vid_a, vid_b, vid_c;
    logic signed [MUL_W-1:0]   mx, my;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_add;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   nsel;
    logic signed [ACC_W-1:0]   dval;
    logic [ACC_W-1:0]          nabs;
    logic [DIV_W:0]            trial;
    logic                      ge;
    logic [Q_W-1:0]            lim;
    logic [Q_W-1:0]            mag;
    logic [Q_W-1:0]            sres;

    function automatic logic signed [VEC_W-1:0] comp(input logic [1:0] j, input logic [2:0] id);
        logic signed [VEC_W-1:0] r;
        case (j)
            2'd0:    r = vx_reg[id];
            2'd1:    r = vy_reg[id];
            default: r = vz_reg[id];
        endcase
        return r;
    endfunction

    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mul_last = (ph_reg == 3'(tbw_pkg::LAST_PH)) && (term_reg == 2'd2) && (det_reg == 3'd4);
    assign div_last = (bit_reg == 6'd0);

    assign j1    = (term_reg == 2'd0) ? 2'd1 : 2'd0;
    assign j2    = (term_reg == 2'd2) ? 2'd1 : 2'd2;
    assign vid_a = tbw_pkg::det_vec(det_reg, 2'd0);
    assign vid_b = tbw_pkg::det_vec(det_reg, 2'd1);
    assign vid_c = tbw_pkg::det_vec(det_reg, 2'd2);

    always_comb begin
        mx = '0;
        my = '0;
        case (ph_reg)
            3'd0: begin
                mx = MUL_W'(comp(j1, vid_b));
                my = MUL_W'(comp(j2, vid_c));
            end
            3'd1: begin
                mx = MUL_W'(comp(j2, vid_b));
                my = MUL_W'(comp(j1, vid_c));
            end
            3'd3: begin
                mx = $signed({{(MUL_W-SPLIT){1'b0}}, minor_reg[SPLIT-1:0]});
                my = MUL_W'(comp(term_reg, vid_a));
            end
            3'd4: begin
                mx = MUL_W'($signed(minor_reg[MINOR_W-1:SPLIT]));
                my = MUL_W'(comp(term_reg, vid_a));
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign prod     = mx * my;
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_add  = (ph_reg == 3'd4) ? prod_ext : (prod_ext <<< SPLIT);
    assign acc_sum  = (term_reg == 2'd1) ? (acc_reg - acc_add) : (acc_reg + acc_add);

    assign nsel  = dets_reg[3'(widx_reg) + 3'd1];
    assign dval  = dets_reg[0];
    assign nabs  = nsel[ACC_W-1] ? ~nsel : nsel;
    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign ge    = !trial[DIV_W];
    assign lim   = neg_reg ? Q_W'(34'h080000000) : Q_W'(34'h07FFFFFFF);
    assign mag   = (ovf_reg || (q_reg > lim)) ? lim : q_reg;
    assign sres  = neg_reg ? (~mag + Q_W'(1)) : mag;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tbw_pkg::ST_IDLE: begin
                if (in_beat && (s_slot == tbw_pkg::SLOT_QUERY)) state_next = tbw_pkg::ST_MUL;
            end
            tbw_pkg::ST_MUL:  if (mul_last) state_next = tbw_pkg::ST_PREP;
            tbw_pkg::ST_PREP: state_next = (dval == '0) ? tbw_pkg::ST_OUT : tbw_pkg::ST_DSET;
            tbw_pkg::ST_DSET: state_next = tbw_pkg::ST_DIV;
            tbw_pkg::ST_DIV:  if (div_last) state_next = tbw_pkg::ST_WFIN;
            tbw_pkg::ST_WFIN: state_next = (widx_reg == 2'd3) ? tbw_pkg::ST_OUT : tbw_pkg::ST_DSET;
            tbw_pkg::ST_OUT:  if (out_free) state_next = tbw_pkg::ST_IDLE;
            default:          state_next = tbw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == tbw_pkg::ST_IDLE);
        m_valid = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tbw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            det_reg     <= '0;
            term_reg    <= '0;
            ph_reg      <= '0;
            widx_reg    <= '0;
            bit_reg     <= '0;
            for (int i = 0; i < tbw_pkg::NUM_VERTS; i++) begin
                for (int k = 0; k < 3; k++) vtx_reg[i][k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // raise valid as a finished beat loads, drop it once taken
            if ((state_reg == tbw_pkg::ST_OUT) && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                tbw_pkg::ST_IDLE: begin
                    if (in_beat && (s_slot < tbw_pkg::SLOT_QUERY)) begin
                        vtx_reg[s_slot[1:0]][0] <= s_coord_x;
                        vtx_reg[s_slot[1:0]][1] <= s_coord_y;
                        vtx_reg[s_slot[1:0]][2] <= s_coord_z;
                    end
                    det_reg  <= '0;
                    term_reg <= '0;
                    ph_reg   <= '0;
                    widx_reg <= '0;
                end
                tbw_pkg::ST_MUL: begin
                    if (ph_reg == 3'(tbw_pkg::LAST_PH)) begin
                        ph_reg <= '0;
                        if (term_reg == 2'd2) begin
                            term_reg <= '0;
                            det_reg  <= det_reg + 3'd1;
                        end else begin
                            term_reg <= term_reg + 2'd1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                tbw_pkg::ST_DSET: bit_reg <= 6'(Q_W);
                tbw_pkg::ST_DIV:  bit_reg <= bit_reg - 6'd1;
                tbw_pkg::ST_WFIN: widx_reg <= widx_reg + 2'd1;
                default: ;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        case (state_reg)
            tbw_pkg::ST_IDLE: begin
                acc_reg <= '0;
                if (in_beat) begin
                    for (int k = 0; k < 3; k++) begin
                        vx_reg[k]   <= VEC_W'($signed(vtx_reg[k+1][0]))
                                     - VEC_W'($signed(vtx_reg[0][0]));
                        vy_reg[k]   <= VEC_W'($signed(vtx_reg[k+1][1]))
                                     - VEC_W'($signed(vtx_reg[0][1]));
                        vz_reg[k]   <= VEC_W'($signed(vtx_reg[k+1][2]))
                                     - VEC_W'($signed(vtx_reg[0][2]));
                        vx_reg[k+3] <= VEC_W'($signed(vtx_reg[k+1][0])) - VEC_W'(s_coord_x);
                        vy_reg[k+3] <= VEC_W'($signed(vtx_reg[k+1][1])) - VEC_W'(s_coord_y);
                        vz_reg[k+3] <= VEC_W'($signed(vtx_reg[k+1][2])) - VEC_W'(s_coord_z);
                    end
                    vx_reg[6] <= VEC_W'(s_coord_x) - VEC_W'($signed(vtx_reg[0][0]));
                    vy_reg[6] <= VEC_W'(s_coord_y) - VEC_W'($signed(vtx_reg[0][1]));
                    vz_reg[6] <= VEC_W'(s_coord_z) - VEC_W'($signed(vtx_reg[0][2]));
                end
            end
            tbw_pkg::ST_MUL: begin
                case (ph_reg)
                    3'd0: prod_reg <= prod;
                    3'd1: begin
                        prod_reg  <= prod;
                        minor_reg <= MINOR_W'($signed(prod_reg[PAIR_W-1:0]));
                    end
                    3'd2: minor_reg <= minor_reg - MINOR_W'($signed(prod_reg[PAIR_W-1:0]));
                    3'd3: prod_reg <= prod;
                    3'd4: begin
                        prod_reg <= prod;
                        acc_reg  <= acc_sum;
                    end
                    default: begin
                        // close the term; store the determinant after its third term
                        if (term_reg == 2'd2) begin
                            dets_reg[det_reg] <= acc_sum;
                            acc_reg           <= '0;
                        end else begin
                            acc_reg <= acc_sum;
                        end
                    end
                endcase
            end
            tbw_pkg::ST_PREP: begin
                ad_reg  <= dval[ACC_W-1] ? ACC_W'(-dval) : dval;
                deg_reg <= (dval == '0);
                if (dval == '0) begin
                    for (int i = 0; i < tbw_pkg::NUM_VERTS; i++) wt_reg[i] <= '0;
                end
            end
            tbw_pkg::ST_DSET: begin
                neg_reg <= nsel[ACC_W-1] ^ dval[ACC_W-1];
                rem_reg <= (DIV_W'(nabs) << (tbw_pkg::FRAC_OUT + 1)) + DIV_W'(ad_reg)
                         + (nsel[ACC_W-1] ? (DIV_W'(1) << (tbw_pkg::FRAC_OUT + 1)) : '0);
                dsh_reg <= DIV_W'(ad_reg) << (Q_W + 1);
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end
            tbw_pkg::ST_DIV: begin
                if (ge) rem_reg <= trial[DIV_W-1:0];
                dsh_reg <= dsh_reg >> 1;
                if (bit_reg == 6'(Q_W)) ovf_reg <= ge;
                else q_reg <= {q_reg[Q_W-2:0], ge};
            end
            tbw_pkg::ST_WFIN: wt_reg[widx_reg] <= sres[OUT_W-1:0];
            tbw_pkg::ST_OUT: begin
                if (out_free) begin
                    m_weight_a   <= wt_reg[0];
                    m_weight_b   <= wt_reg[1];
                    m_weight_c   <= wt_reg[2];
                    m_weight_d   <= wt_reg[3];
                    m_degenerate <= deg_reg;
                end
            end
            default: ;
        endcase
    end

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> ((m_weight_a == '0) && (m_weight_b == '0)
                                    && (m_weight_c == '0) && (m_weight_d == '0)))
        else $error("degenerate beat carries nonzero weights");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && (s_slot == tbw_pkg::SLOT_QUERY)) |=> !s_ready)
        else $error("ready after a query beat");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && in_beat && (s_slot != tbw_pkg::SLOT_QUERY)) |=> !m_valid)
        else $error("result raised by a vertex beat");

endmodule

// File: sim/tetrahedron_barycentric_weights_test.sv
module tetrahedron_barycentric_weights_test;

    localparam int NUM_ITEMS   = 1250;
    localparam int LONG_HOLD   = 2000;
    localparam int SETTLE_CYC  = 400;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef logic signed [191:0] big_t;

    typedef struct {
        logic [2:0]  slot;
        logic [31:0] x, y, z;
        bit          drain;
    } beat_t;

    typedef struct {
        logic [31:0] w[4];
        logic        degen;
    } weights_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_slot = '0;
    logic signed [31:0]   s_coord_x = '0, s_coord_y = '0, s_coord_z = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_weight_a, m_weight_b, m_weight_c, m_weight_d;
    logic                 m_degenerate;

    beat_t    pending[$];
    weights_t expected_weights[$];
    big_t     vert_x[4], vert_y[4], vert_z[4];
    int       gap_cnt = 0;
    int       hold_cnt = 0;
    int       fail_cnt = 0;
    int       result_cnt = 0;
    int       query_cnt = 0;
    int       degen_cnt = 0;
    int       sat_cnt = 0;

    tetrahedron_barycentric_weights DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_slot(s_slot),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_coord_z(s_coord_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_weight_a(m_weight_a), .m_weight_b(m_weight_b),
        .m_weight_c(m_weight_c), .m_weight_d(m_weight_d),
        .m_degenerate(m_degenerate)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic big_t det3(big_t a0, big_t a1, big_t a2, big_t b0, big_t b1, big_t b2,
                                  big_t c0, big_t c1, big_t c2);
        return a0 * (b1 * c2 - b2 * c1) - a1 * (b0 * c2 - b2 * c0)
             + a2 * (b0 * c1 - b1 * c0);
    endfunction

    // round(n * 2^28 / d), ties away from zero, saturated to Q4.28
    function automatic logic [31:0] weight_ratio(big_t n, big_t d);
        logic        neg;
        logic [191:0] an, ad, q, lim, mag;
        neg = n[191] ^ d[191];
        an  = n[191] ? -n : n;
        ad  = d[191] ? -d : d;
        q   = ((an << (tbw_pkg::FRAC_OUT + 1)) + ad) / (ad << 1);
        lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        mag = (q > lim) ? lim : q;
        if (q > lim) sat_cnt++;
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    task automatic predict_weights(logic [2:0] slot, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z);
        big_t px, py, pz, e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z, gx, gy, gz, den;
        big_t num[4];
        weights_t r;
        px = $signed(x);
        py = $signed(y);
        pz = $signed(z);
        if (slot < tbw_pkg::SLOT_QUERY) begin
            vert_x[slot] = px;
            vert_y[slot] = py;
            vert_z[slot] = pz;
        end else if (slot == tbw_pkg::SLOT_QUERY) begin
            e0x = vert_x[1] - vert_x[0]; e0y = vert_y[1] - vert_y[0]; e0z = vert_z[1] - vert_z[0];
            e1x = vert_x[2] - vert_x[0]; e1y = vert_y[2] - vert_y[0]; e1z = vert_z[2] - vert_z[0];
            e2x = vert_x[3] - vert_x[0]; e2y = vert_y[3] - vert_y[0]; e2z = vert_z[3] - vert_z[0];
            gx = px - vert_x[0]; gy = py - vert_y[0]; gz = pz - vert_z[0];
            den = det3(e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z);
            num[0] = det3(vert_x[1] - px, vert_y[1] - py, vert_z[1] - pz,
                          vert_x[2] - px, vert_y[2] - py, vert_z[2] - pz,
                          vert_x[3] - px, vert_y[3] - py, vert_z[3] - pz);
            num[1] = det3(gx, gy, gz, e1x, e1y, e1z, e2x, e2y, e2z);
            num[2] = det3(e0x, e0y, e0z, gx, gy, gz, e2x, e2y, e2z);
            num[3] = det3(e0x, e0y, e0z, e1x, e1y, e1z, gx, gy, gz);
            query_cnt++;
            r.degen = (den == 0);
            if (r.degen) degen_cnt++;
            for (int i = 0; i < 4; i++) r.w[i] = r.degen ? 32'd0 : weight_ratio(num[i], den);
            expected_weights.push_back(r);
        end
    endtask

    task automatic add_beat(logic [2:0] slot, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit drain = 0);
        beat_t b;
        b.slot = slot; b.x = x; b.y = y; b.z = z; b.drain = drain;
        pending.push_back(b);
    endtask

    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 32'($signed($urandom_range(0, 16)) - 8) << 16 | 32'($urandom_range(0, 255));
        if (k < 60) return $urandom;
        if (k < 70) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0;
                3: return 32'hFFFF_FFFF;
                default: return 32'h1;
            endcase
        end
        return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endfunction

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", result_cnt, what, got, want);
        fail_cnt++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_weights(s_slot, s_coord_x, s_coord_y, s_coord_z);
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                s_valid <= 1'b0;
            end else if (pending.size() == 0 ||
                         (pending[0].drain && (expected_weights.size() != 0 || s_valid))) begin
                s_valid <= 1'b0;
            end else begin
                s_slot    <= pending[0].slot;
                s_coord_x <= pending[0].x;
                s_coord_y <= pending[0].y;
                s_coord_z <= pending[0].z;
                s_valid   <= 1'b1;
                pending.pop_front();
                gap_cnt   <= rand_gap();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_weights.size() == 0) begin
                    $display("unexpected result beat %0d", result_cnt);
                    fail_cnt++;
                end else begin
                    if (m_weight_a !== expected_weights[0].w[0])
                        report_mismatch("weight_a", m_weight_a, expected_weights[0].w[0]);
                    if (m_weight_b !== expected_weights[0].w[1])
                        report_mismatch("weight_b", m_weight_b, expected_weights[0].w[1]);
                    if (m_weight_c !== expected_weights[0].w[2])
                        report_mismatch("weight_c", m_weight_c, expected_weights[0].w[2]);
                    if (m_weight_d !== expected_weights[0].w[3])
                        report_mismatch("weight_d", m_weight_d, expected_weights[0].w[3]);
                    if (m_degenerate !== expected_weights[0].degen)
                        report_mismatch("degenerate", 32'(m_degenerate),
                                        32'(expected_weights[0].degen));
                    expected_weights.pop_front();
                end
                result_cnt++;
                // hold off long enough for the input side to back up
                if (result_cnt == 12 || result_cnt == 250) hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (rand_gap() == 0);
            end
        end
    end

    initial begin
        int n, q, order;
        logic [31:0] s;
        for (int i = 0; i < 4; i++) begin
            vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
        end
        // query with an empty store, then unused slots
        add_beat(tbw_pkg::SLOT_QUERY, ONE, ONE, ONE);
        add_beat(3'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        add_beat(3'd6, 32'h0, 32'hFFFF_FFFF, 32'h0);
        add_beat(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        // unit tetrahedron
        add_beat(3'd0, 0, 0, 0);
        add_beat(3'd1, ONE, 0, 0);
        add_beat(3'd2, 0, ONE, 0);
        add_beat(3'd3, 0, 0, ONE);
        add_beat(tbw_pkg::SLOT_QUERY, 32'h4000, 32'h4000, 32'h4000);
        add_beat(tbw_pkg::SLOT_QUERY, ONE, 0, 0);
        add_beat(tbw_pkg::SLOT_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_beat(tbw_pkg::SLOT_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // tiny tetrahedron, far query saturates
        add_beat(3'd1, 32'h1, 0, 0);
        add_beat(3'd2, 0, 32'h1, 0);
        add_beat(3'd3, 0, 0, 32'h1);
        add_beat(tbw_pkg::SLOT_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        // extreme vertices
        add_beat(3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        add_beat(3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_beat(3'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_beat(3'd3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_beat(tbw_pkg::SLOT_QUERY, 32'h0, 32'h0, 32'h0);
        add_beat(tbw_pkg::SLOT_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // flat tetrahedron
        add_beat(3'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_beat(tbw_pkg::SLOT_QUERY, ONE, ONE, ONE);
        n = 24;
        while (n < NUM_ITEMS) begin
            q = $urandom_range(0, 99);
            if (q < 75) begin
                order = $urandom_range(0, 3);
                for (int i = 0; i < 4; i++)
                    add_beat(3'((i + order) % 4), rand_coord(), rand_coord(), rand_coord(),
                             (i == 0) && (n % 300 < 6));
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    add_beat(tbw_pkg::SLOT_QUERY, rand_coord(), rand_coord(), rand_coord());
                n += 6;
            end else if (q < 90) begin
                add_beat(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
                n++;
            end else begin
                // collapse the tetrahedron onto the plane z = s
                s = rand_coord();
                for (int i = 0; i < 4; i++)
                    add_beat(3'(i), rand_coord(), rand_coord(), s);
                add_beat(3'($urandom_range(1, 3)), 0, 0, s);
                add_beat(tbw_pkg::SLOT_QUERY, rand_coord(), rand_coord(), rand_coord());
                n += 6;
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending.size() != 0 || s_valid || expected_weights.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        $display("%0d query results checked, %0d degenerate, %0d saturated weights",
                 result_cnt, degen_cnt, sat_cnt);
        $display("%0d queries predicted over random, extreme and flat tetrahedra", query_cnt);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("timeout with %0d results outstanding", expected_weights.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tbw_pkg.sv
hw/rtl/tetrahedron_barycentric_weights.sv
sim/tetrahedron_barycentric_weights_test.sv
